// File: rtl/sfr_pkg.sv
// sfr_pkg: shared types, protocol constants and header byte helpers
// for the spi framed request responder. No dependencies.
`default_nettype none

package sfr_pkg;

	localparam int unsigned SFR_MAX_PAYLOAD = 16384;
	localparam int unsigned HDR_LEN         = 16;

	localparam logic [31:0] MAGIC_WORD = 32'h5350_4931;
	localparam logic [7:0]  FLAG_REQ   = 8'h01;
	localparam logic [7:0]  FLAG_RSP   = 8'h02;
	localparam logic [7:0]  CMD_PING   = 8'h01;
	localparam logic [7:0]  CMD_PROC   = 8'h02;
	localparam logic [7:0]  ST_HDR_OK  = 8'h10;
	localparam logic [7:0]  ST_OK      = 8'h80;
	localparam logic [7:0]  ST_BAD_HDR = 8'hE1;
	localparam logic [7:0]  ST_BAD_LEN = 8'hE2;
	localparam logic [7:0]  ST_BAD_CMD = 8'hE3;
	localparam logic [7:0]  XOR_KEY    = 8'hA5;
	localparam logic [31:0] PONG_LEN   = 32'd4;

	typedef enum logic [2:0] {
		PH_REQ_HDR = 3'd0,
		PH_ACK_HDR = 3'd1,
		PH_REQ_PAY = 3'd2,
		PH_RSP_HDR = 3'd3,
		PH_RSP_PAY = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       abort;
	} slot_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		phase_t     phase;
		logic       phase_last;
		logic       exchange_done;
	} reply_t;

	// engine position, seen by the top level checks
	typedef struct packed {
		phase_t phase;
		logic   idx_zero;
	} eng_stat_t;

	// big-endian byte sel of a 32-bit word
	function automatic logic [7:0] word_byte(logic [31:0] w, logic [1:0] sel);
		logic [7:0] b;
		unique case (sel)
			2'd0: b = w[31:24];
			2'd1: b = w[23:16];
			2'd2: b = w[15:8];
			default: b = w[7:0];
		endcase
		return b;
	endfunction

	function automatic logic [7:0] hdr_byte(logic [3:0] pos, logic [31:0] seq,
			logic [31:0] len, logic [7:0] cmd, logic [7:0] status);
		logic [7:0] b;
		unique case (pos[3:2])
			2'd0: b = word_byte(MAGIC_WORD, pos[1:0]);
			2'd1: b = word_byte(seq, pos[1:0]);
			2'd2: b = word_byte(len, pos[1:0]);
			default: begin
				unique case (pos[1:0])
					2'd0: b = cmd;
					2'd1: b = status;
					2'd2: b = FLAG_RSP;
					default: b = 8'h00;
				endcase
			end
		endcase
		return b;
	endfunction

	// "PONG"
	function automatic logic [7:0] pong_byte(logic [1:0] sel);
		logic [7:0] b;
		unique case (sel)
			2'd0: b = 8'h50;
			2'd1: b = 8'h4F;
			2'd2: b = 8'h4E;
			default: b = 8'h47;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sfr_ram.sv
// sfr_ram: generic single write port, single read port ram with registered read.
// No dependencies.
`default_nettype none

module sfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16384,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/sfr_engine.sv
// sfr_engine: transaction state, header checks and reply byte generation.
// Depends on sfr_pkg; drives the payload store ports of sfr_ram.
`default_nettype none

module sfr_engine
	import sfr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = SFR_MAX_PAYLOAD,
	localparam int unsigned AW    = $clog2(MAX_PAYLOAD),
	localparam int unsigned IDX_W = (AW > 4) ? AW : 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire slot_t         slot,
	input  wire logic [7:0]    rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [7:0]         wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	output reply_t             res,
	output eng_stat_t          stat
);

	localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_LEN - 1);
	localparam logic [31:0]      MAX_LEN  = 32'(MAX_PAYLOAD);

	phase_t           phase_q, phase_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic [31:0]      seq_q, seq_n;
	logic [31:0]      len_q, len_n;
	logic [7:0]       cmd_q, cmd_n;
	logic [7:0]       verdict_q, verdict_n;

	logic [3:0]       hi;
	logic             bad;
	logic [7:0]       verd_hdr;
	logic [7:0]       ack_status;
	logic [31:0]      rsp_len;
	logic [31:0]      idx_inc;
	logic             hdr_end;

	assign hi         = idx_q[3:0];
	assign hdr_end    = (idx_q == HDR_LAST);
	assign idx_inc    = 32'(idx_q) + 32'd1;
	assign rsp_len    = (cmd_q == CMD_PING) ? PONG_LEN : len_q;
	assign ack_status = (verdict_q == ST_OK) ? ST_HDR_OK : verdict_q;
	assign verd_hdr   = bad ? ST_BAD_HDR : verdict_q;

	// request header field checks
	always_comb begin
		bad = 1'b0;
		priority if (hi < 4'd4) begin
			bad = (slot.rx_byte != word_byte(MAGIC_WORD, hi[1:0]));
		end else if (hi == 4'd13) begin
			bad = (slot.rx_byte != 8'h00);
		end else if (hi == 4'd14) begin
			bad = (slot.rx_byte != FLAG_REQ);
		end else if (hi == 4'd15) begin
			bad = (slot.rx_byte != 8'h00);
		end else begin
			bad = 1'b0;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		seq_n     = seq_q;
		len_n     = len_q;
		cmd_n     = cmd_q;
		verdict_n = verdict_q;
		res       = '{tx_byte: 8'h00, phase: phase_q, phase_last: 1'b0,
			exchange_done: 1'b0};
		wr_en     = 1'b0;

		if (slot.abort) begin
			res.exchange_done = 1'b1;
			phase_n   = PH_REQ_HDR;
			idx_n     = '0;
			verdict_n = 8'h00;
		end else begin
			unique case (phase_q)
				PH_REQ_HDR: begin
					verdict_n = verd_hdr;
					if (hi >= 4'd4 && hi < 4'd8) begin
						seq_n = {seq_q[23:0], slot.rx_byte};
					end
					if (hi >= 4'd8 && hi < 4'd12) begin
						len_n = {len_q[23:0], slot.rx_byte};
					end
					if (hi == 4'd12) begin
						cmd_n = slot.rx_byte;
					end
					if (hdr_end) begin
						res.phase_last = 1'b1;
						phase_n = PH_ACK_HDR;
						idx_n   = '0;
						// final verdict; length and command are complete by now
						if (verd_hdr != ST_BAD_HDR) begin
							priority if (len_q > MAX_LEN) begin
								verdict_n = ST_BAD_LEN;
							end else if (cmd_q == CMD_PING) begin
								verdict_n = (len_q == 32'd0) ? ST_OK : ST_BAD_LEN;
							end else if (cmd_q == CMD_PROC) begin
								verdict_n = (len_q != 32'd0) ? ST_OK : ST_BAD_LEN;
							end else begin
								verdict_n = ST_BAD_CMD;
							end
						end
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
				PH_ACK_HDR: begin
					res.tx_byte = hdr_byte(hi, seq_q, 32'd0, cmd_q, ack_status);
					if (hdr_end) begin
						res.phase_last = 1'b1;
						idx_n = '0;
						if (verdict_q != ST_OK) begin
							res.exchange_done = 1'b1;
							phase_n   = PH_REQ_HDR;
							verdict_n = 8'h00;
						end else begin
							phase_n = (len_q != 32'd0) ? PH_REQ_PAY : PH_RSP_HDR;
						end
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
				PH_REQ_PAY: begin
					wr_en = 1'b1;
					if (idx_inc >= len_q) begin
						res.phase_last = 1'b1;
						phase_n = PH_RSP_HDR;
						idx_n   = '0;
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
				PH_RSP_HDR: begin
					res.tx_byte = hdr_byte(hi, seq_q, rsp_len, cmd_q, ST_OK);
					if (hdr_end) begin
						res.phase_last = 1'b1;
						phase_n = PH_RSP_PAY;
						idx_n   = '0;
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
				PH_RSP_PAY: begin
					res.tx_byte = (cmd_q == CMD_PING) ? pong_byte(idx_q[1:0])
						: (rd_data ^ XOR_KEY);
					if (idx_inc >= rsp_len) begin
						res.phase_last    = 1'b1;
						res.exchange_done = 1'b1;
						phase_n   = PH_REQ_HDR;
						idx_n     = '0;
						verdict_n = 8'h00;
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
				default: begin
					res.phase = PH_REQ_HDR;
					phase_n   = PH_REQ_HDR;
					idx_n     = '0;
					verdict_n = 8'h00;
				end
			endcase
		end
	end

	// payload store: write at the current slot, read one slot ahead
	assign wr_addr = idx_q[AW-1:0];
	assign wr_data = slot.rx_byte;
	assign rd_en   = fire;
	assign rd_addr = idx_n[AW-1:0];

	assign stat = '{phase: phase_q, idx_zero: (idx_q == '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_REQ_HDR;
			idx_q     <= '0;
			seq_q     <= '0;
			len_q     <= '0;
			cmd_q     <= '0;
			verdict_q <= '0;
		end else if (fire) begin
			phase_q   <= phase_n;
			idx_q     <= idx_n;
			seq_q     <= seq_n;
			len_q     <= len_n;
			cmd_q     <= cmd_n;
			verdict_q <= verdict_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/spi_framed_request_responder.sv
// spi_framed_request_responder: top level with input register, result register,
// framing engine and payload store. Depends on sfr_pkg, sfr_engine and sfr_ram.
`default_nettype none

// Each transfer on the slot channel is one full-duplex SPI byte slot and yields
// exactly one transfer on the reply channel, in order. The block takes one slot
// per clock when the reply side keeps up; a slot waits in the input register until
// it is processed and appears on the reply port, from the result register, the cycle
// after it is processed. The payload store is a single ram whose registered read
// is issued one slot ahead, which is what keeps the response payload at one byte
// per clock. The store is not cleared after reset; response bytes only ever come
// from entries written earlier in the same transaction. Asserting abort on a
// slot ends the transaction and returns the block to the request header phase.
module spi_framed_request_responder
	import sfr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = SFR_MAX_PAYLOAD
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   slot_valid,
	output logic        slot_ready,
	input  wire slot_t  slot,
	output logic        reply_valid,
	input  wire logic   reply_ready,
	output reply_t      reply
);

	localparam int unsigned AW = $clog2(MAX_PAYLOAD);

	logic         valid_s1;
	slot_t        slot_s1;
	logic         proc_fire;
	logic         reply_valid_q;
	reply_t       reply_q;
	reply_t       res;
	eng_stat_t    stat;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign proc_fire  = valid_s1 && (!reply_valid_q || reply_ready);
	assign slot_ready = !valid_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (slot_ready) begin
			valid_s1 <= slot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_ready && slot_valid) begin
			slot_s1 <= slot;
		end
	end

	sfr_engine #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (proc_fire),
		.slot    (slot_s1),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.res     (res),
		.stat    (stat)
	);

	sfr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (wr_en && proc_fire),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_valid_q <= 1'b0;
		end else if (proc_fire) begin
			reply_valid_q <= 1'b1;
		end else if (reply_ready) begin
			reply_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire) begin
			reply_q <= res;
		end
	end

	assign reply_valid = reply_valid_q;
	assign reply       = reply_q;

	// abort always lands the engine at the start of a request header
	a_abort_idle: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire && slot_s1.abort |=> stat.phase == PH_REQ_HDR && stat.idx_zero)
		else $error("engine not idle after abort");

	a_fire_reply: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire |=> reply_valid_q)
		else $error("processed slot produced no reply");

	a_rx_phase_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid_q && (reply_q.phase == PH_REQ_HDR || reply_q.phase == PH_REQ_PAY)
		|-> reply_q.tx_byte == 8'h00)
		else $error("nonzero byte driven in a receive phase");

	a_rsp_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid_q && reply_q.phase == PH_RSP_PAY && reply_q.phase_last
		|-> reply_q.exchange_done)
		else $error("response payload ended without exchange done");

endmodule

`default_nettype wire

// File: test/spi_framed_request_responder_tb.sv
// spi_framed_request_responder_tb: self-checking bench for the spi framing engine.
// Tracks each exchange slot by slot and checks every reply transfer in order.
// Depends on sfr_pkg and the spi_framed_request_responder top level.
import sfr_pkg::*;

class exchange_tracker;
	phase_t      cur_phase;
	int unsigned pos;
	logic [31:0] seq_no;
	logic [31:0] req_len;
	logic [7:0]  cmd;
	logic [7:0]  verdict;
	logic [7:0]  store [SFR_MAX_PAYLOAD];
	reply_t      due_replies [$];
	int unsigned errors;
	int unsigned checked;

	function new();
		to_idle();
		seq_no = '0;
		req_len = '0;
		cmd = '0;
		errors = 0;
		checked = 0;
	endfunction

	function void to_idle();
		cur_phase = PH_REQ_HDR;
		pos = 0;
		verdict = 8'h00;
	endfunction

	function bit busy();
		return cur_phase != PH_REQ_HDR || pos != 0;
	endfunction

	function logic [31:0] answer_len();
		return (cmd == CMD_PING) ? PONG_LEN : req_len;
	endfunction

	function logic [7:0] header_out(int unsigned p, logic [31:0] len, logic [7:0] status);
		logic [127:0] hdr;
		hdr = {MAGIC_WORD, seq_no, len, cmd, status, FLAG_RSP, 8'h00};
		return hdr[127 - 8*p -: 8];
	endfunction

	function void note_slot(slot_t s);
		reply_t      r;
		logic [31:0] w;
		logic [31:0] pong;
		pong = "PONG";
		r.tx_byte = 8'h00;
		r.phase = cur_phase;
		r.phase_last = 1'b0;
		r.exchange_done = 1'b0;
		if (s.abort) begin
			r.exchange_done = 1'b1;
			to_idle();
		end else begin
			case (cur_phase)
				PH_REQ_HDR: begin
					if (pos < 4) begin
						w = MAGIC_WORD >> (8 * (3 - pos));
						if (s.rx_byte != w[7:0])
							verdict = ST_BAD_HDR;
					end else if (pos < 8) begin
						seq_no = {seq_no[23:0], s.rx_byte};
					end else if (pos < 12) begin
						req_len = {req_len[23:0], s.rx_byte};
					end else if (pos == 12) begin
						cmd = s.rx_byte;
					end else if (pos == 13) begin
						if (s.rx_byte != 8'h00)
							verdict = ST_BAD_HDR;
					end else if (pos == 14) begin
						if (s.rx_byte != FLAG_REQ)
							verdict = ST_BAD_HDR;
					end else if (s.rx_byte != 8'h00) begin
						verdict = ST_BAD_HDR;
					end
					if (pos == HDR_LEN - 1) begin
						r.phase_last = 1'b1;
						// malformed bytes win over length and command checks
						if (verdict != ST_BAD_HDR) begin
							if (req_len > SFR_MAX_PAYLOAD)
								verdict = ST_BAD_LEN;
							else if (cmd == CMD_PING)
								verdict = (req_len == 0) ? ST_OK : ST_BAD_LEN;
							else if (cmd == CMD_PROC)
								verdict = (req_len != 0) ? ST_OK : ST_BAD_LEN;
							else
								verdict = ST_BAD_CMD;
						end
						cur_phase = PH_ACK_HDR;
						pos = 0;
					end else begin
						pos++;
					end
				end
				PH_ACK_HDR: begin
					r.tx_byte = header_out(pos, 32'd0, (verdict == ST_OK) ? ST_HDR_OK : verdict);
					if (pos == HDR_LEN - 1) begin
						r.phase_last = 1'b1;
						if (verdict != ST_OK) begin
							r.exchange_done = 1'b1;
							to_idle();
						end else begin
							cur_phase = (req_len != 0) ? PH_REQ_PAY : PH_RSP_HDR;
							pos = 0;
						end
					end else begin
						pos++;
					end
				end
				PH_REQ_PAY: begin
					store[pos] = s.rx_byte;
					if (pos + 1 >= req_len) begin
						r.phase_last = 1'b1;
						cur_phase = PH_RSP_HDR;
						pos = 0;
					end else begin
						pos++;
					end
				end
				PH_RSP_HDR: begin
					r.tx_byte = header_out(pos, answer_len(), ST_OK);
					if (pos == HDR_LEN - 1) begin
						r.phase_last = 1'b1;
						cur_phase = PH_RSP_PAY;
						pos = 0;
					end else begin
						pos++;
					end
				end
				PH_RSP_PAY: begin
					if (cmd == CMD_PING)
						r.tx_byte = pong[31 - 8*(pos % 4) -: 8];
					else
						r.tx_byte = store[pos] ^ XOR_KEY;
					if (pos + 1 >= answer_len()) begin
						r.phase_last = 1'b1;
						r.exchange_done = 1'b1;
						to_idle();
					end else begin
						pos++;
					end
				end
				default: to_idle();
			endcase
		end
		due_replies.push_back(r);
	endfunction

	function void check_reply(reply_t got);
		reply_t want;
		if (due_replies.size() == 0) begin
			$error("reply transfer with nothing expected: tx_byte %02h phase %0d",
				got.tx_byte, got.phase);
			errors++;
			return;
		end
		want = due_replies.pop_front();
		checked++;
		if (got.tx_byte !== want.tx_byte) begin
			$error("tx_byte: expected %02h, actual %02h", want.tx_byte, got.tx_byte);
			errors++;
		end
		if (got.phase !== want.phase) begin
			$error("phase: expected %0d, actual %0d", want.phase, got.phase);
			errors++;
		end
		if (got.phase_last !== want.phase_last) begin
			$error("phase_last: expected %0b, actual %0b", want.phase_last, got.phase_last);
			errors++;
		end
		if (got.exchange_done !== want.exchange_done) begin
			$error("exchange_done: expected %0b, actual %0b",
				want.exchange_done, got.exchange_done);
			errors++;
		end
	endfunction
endclass

module spi_framed_request_responder_tb;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned PHASE_SLOTS = 30;

	typedef struct {
		logic [31:0] magic;
		logic [31:0] seq;
		logic [31:0] len;
		logic [7:0]  cmd;
		logic [7:0]  status;
		logic [7:0]  flags;
		logic [7:0]  rsvd;
	} request_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   slot_valid = 1'b0;
	logic   slot_ready;
	slot_t  slot = '0;
	logic   reply_valid;
	logic   reply_ready = 1'b0;
	reply_t reply;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned stall = 0;
	int unsigned slots_sent = 0;
	int unsigned exchanges = 0;
	int unsigned aborts_sent = 0;

	exchange_tracker tracker = new();

	spi_framed_request_responder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.slot_valid  (slot_valid),
		.slot_ready  (slot_ready),
		.slot        (slot),
		.reply_valid (reply_valid),
		.reply_ready (reply_ready),
		.reply       (reply)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random idling, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= LONG_HOLD;
			reply_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			reply_ready <= 1'b0;
		end else begin
			reply_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && reply_valid && reply_ready)
			tracker.check_reply(reply);
	end

	always @(posedge clk) begin
		if (!arst_n || (slot_valid && slot_ready) || (reply_valid && reply_ready)) begin
			stall <= 0;
		end else begin
			stall <= stall + 1;
			if (stall >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_slot(input logic [7:0] rx, input logic ab);
		slot_t s;
		s.rx_byte = rx;
		s.abort = ab;
		while ($urandom_range(99) < send_idle_pct) begin
			slot_valid <= 1'b0;
			@(posedge clk);
		end
		slot_valid <= 1'b1;
		slot <= s;
		do @(posedge clk); while (!slot_ready);
		tracker.note_slot(s);
		slots_sent++;
		if (ab)
			aborts_sent++;
	endtask

	// random bytes until the engine is back at the start of a request header
	task automatic finish_exchange(input int k, input int abort_at);
		while (tracker.busy()) begin
			send_slot($urandom_range(255), k == abort_at);
			k++;
		end
	endtask

	task automatic run_exchange(input request_t h, input int abort_at);
		logic [127:0] flat;
		flat = {h.magic, h.seq, h.len, h.cmd, h.status, h.flags, h.rsvd};
		for (int k = 0; k < HDR_LEN; k++)
			send_slot(flat[127 - 8*k -: 8], k == abort_at);
		finish_exchange(HDR_LEN, abort_at);
		exchanges++;
	endtask

	task automatic wait_for_replies();
		slot_valid <= 1'b0;
		while (tracker.due_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic request_t make_request(input logic [7:0] cmd, input logic [31:0] len);
		request_t h;
		h.magic = MAGIC_WORD;
		h.seq = $urandom();
		h.len = len;
		h.cmd = cmd;
		h.status = 8'h00;
		h.flags = FLAG_REQ;
		h.rsvd = 8'h00;
		return h;
	endfunction

	// mostly short payloads keep exchanges brief
	function automatic logic [31:0] payload_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 85)
			return $urandom_range(1, 8);
		else if (r < 98)
			return $urandom_range(9, 64);
		return $urandom_range(65, 128);
	endfunction

	function automatic request_t random_request();
		request_t    h;
		int unsigned pick;
		pick = $urandom_range(23);
		h = make_request(CMD_PROC, payload_len());
		if (pick < 6) begin
			h.cmd = CMD_PING;
			h.len = 32'd0;
		end else if (pick == 16) begin
			h.magic ^= 32'd1 << $urandom_range(31);
		end else if (pick == 17) begin
			h.status = $urandom_range(1, 255);
		end else if (pick == 18) begin
			h.flags = $urandom_range(255);
			if (h.flags == FLAG_REQ)
				h.flags = 8'h00;
		end else if (pick == 19) begin
			h.rsvd = $urandom_range(1, 255);
		end else if (pick == 20) begin
			h.len = $urandom_range(1) ? SFR_MAX_PAYLOAD + 1
				: $urandom_range(32'hFFFF_FFFF, SFR_MAX_PAYLOAD + 1);
		end else if (pick == 21) begin
			h.cmd = CMD_PING;
			h.len = $urandom_range(1, 8);
		end else if (pick == 22) begin
			h.len = 32'd0;
		end else if (pick == 23) begin
			h.cmd = $urandom_range(255);
			if (h.cmd == CMD_PING || h.cmd == CMD_PROC)
				h.cmd = 8'h03;
		end
		return h;
	endfunction

	task automatic directed_exchanges();
		request_t h;
		int       cut [3] = '{15, 20, 52};
		send_slot(8'hFF, 1'b1);    // abort while idle
		h = make_request(CMD_PING, 32'd0);
		h.seq = 32'hFFFF_FFFF;
		run_exchange(h, -1);
		h = make_request(CMD_PROC, 32'd1);
		h.seq = 32'h0000_0000;
		run_exchange(h, -1);
		// bad magic must win over an oversize length
		h = make_request(CMD_PROC, 32'hFFFF_FFFF);
		h.magic ^= 32'hFF00_0000;
		run_exchange(h, -1);
		run_exchange(make_request(CMD_PROC, SFR_MAX_PAYLOAD + 1), -1);
		run_exchange(make_request(CMD_PING, 32'd4), -1);
		run_exchange(make_request(CMD_PROC, 32'd0), -1);
		run_exchange(make_request(8'hFF, 32'd1), -1);
		h = make_request(CMD_PROC, 32'd2);
		h.status = 8'hFF;
		run_exchange(h, -1);
		// aborts landing in several phases of a 4-byte process exchange
		foreach (cut[i])
			run_exchange(make_request(CMD_PROC, 32'd4), cut[i]);
	endtask

	task automatic random_exchanges(input int unsigned goal);
		int unsigned start;
		int unsigned r;
		request_t    h;
		start = slots_sent;
		while (slots_sent - start < goal) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_slot($urandom_range(255), 1'b1);
			end else if (r < 10) begin
				// stray bytes, then whatever it takes to get back in frame
				repeat ($urandom_range(1, 20))
					send_slot($urandom_range(255), $urandom_range(15) == 0);
				finish_exchange(0, -1);
			end else begin
				h = random_request();
				run_exchange(h, ($urandom_range(99) < 10) ? $urandom_range(60) : -1);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 20;
		recv_idle_pct <= 81;
		@(posedge clk);
		directed_exchanges();

		// long receiver hold while the sender keeps pushing slots
		hold_asks <= hold_asks + 1;
		run_exchange(make_request(CMD_PROC, 32'd8), -1);
		random_exchanges(PHASE_SLOTS);
		wait_for_replies();

		send_idle_pct = 81;
		recv_idle_pct <= 20;
		random_exchanges(PHASE_SLOTS);
		wait_for_replies();

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		random_exchanges(PHASE_SLOTS);
		wait_for_replies();
		repeat (8) @(posedge clk);

		$display("run: %0d slots over %0d exchanges, %0d aborts, %0d replies checked",
			slots_sent, exchanges, aborts_sent, tracker.checked);
		$display("run: ping and short process exchanges, header rejections, stalls on both sides");
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
